>>> hw/rtl/erle_pkg.sv
`timescale 1ns / 1ps

package erle_pkg;

    localparam int unsigned MAX_REPEAT_DEF = 65536;
    localparam int unsigned QUEUE_DEPTH    = 2;
    localparam int unsigned MAX_RESULTS    = 3;

    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_TAB  = 8'h09;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_SHORT_HEX     = 3'd1,
        ST_BAD_HEX       = 3'd2,
        ST_BAD_NUMBER    = 3'd3,
        ST_TOO_LARGE     = 3'd4,
        ST_MISSING_VALUE = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        M_IDLE   = 3'd0,
        M_ESC    = 3'd1,
        M_HEX0   = 3'd2,
        M_HEX1   = 3'd3,
        M_TILDE  = 3'd4,
        M_DIGITS = 3'd5,
        M_VALUE  = 3'd6,
        M_DRAIN  = 3'd7
    } t_mode;

    typedef struct packed {
        logic [7:0]  run_byte;
        logic [16:0] run_length;
        logic        is_status;
        t_status     status_code;
    } t_result;

    // all results caused by one input word
    typedef struct packed {
        logic [1:0]                  cnt;
        t_result [MAX_RESULTS-1:0]   res;
    } t_bundle;

    function automatic t_result mk_res(logic [7:0] b, logic [16:0] len, logic st,
                                       t_status code);
        t_result r;
        r.run_byte    = b;
        r.run_length  = len;
        r.is_status   = st;
        r.status_code = code;
        return r;
    endfunction

endpackage

>>> hw/rtl/erle_front.sv
`timescale 1ns / 1ps

module erle_front #(
    parameter int unsigned MAX_REPEAT = erle_pkg::MAX_REPEAT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_char_in,
    input  logic              i_has_char,
    input  logic              i_payload_end,
    input  logic              i_full,
    output logic              o_push,
    output erle_pkg::t_bundle o_bundle
);

    erle_pkg::t_mode r_mode, n_mode;
    logic [3:0]      r_high_nibble, n_high_nibble;
    logic            r_hex_invalid, n_hex_invalid;
    logic [63:0]     r_accum, n_accum;
    logic            r_overflow, n_overflow;
    logic            r_octal, n_octal;
    logic            r_oct_inv, n_oct_inv;

    logic            w_acc;
    logic            w_digit;
    logic [3:0]      w_d;
    logic [3:0]      w_nib;
    logic            w_nib_ok;
    logic [67:0]     w_dec;
    logic            w_idle_go;
    logic [1:0]      w_cnt;
    erle_pkg::t_result [erle_pkg::MAX_RESULTS-1:0] w_res;

    assign w_acc   = i_valid && !i_full;
    assign o_stall = i_full;
    assign w_digit = (i_char_in >= erle_pkg::CH_ZERO) && (i_char_in <= erle_pkg::CH_NINE);
    assign w_d     = i_char_in[3:0];
    assign w_dec   = ({4'd0, r_accum} << 3) + ({4'd0, r_accum} << 1) + {64'd0, w_d};

    always_comb begin
        w_nib_ok = 1'b1;
        w_nib    = 4'd0;
        if (w_digit) begin
            w_nib = i_char_in[3:0];
        end else if ((i_char_in >= 8'h61 && i_char_in <= 8'h66)
                  || (i_char_in >= 8'h41 && i_char_in <= 8'h46)) begin
            w_nib = i_char_in[3:0] + 4'd9;
        end else begin
            w_nib_ok = 1'b0;
        end
    end

    always_comb begin
        n_mode        = r_mode;
        n_high_nibble = r_high_nibble;
        n_hex_invalid = r_hex_invalid;
        n_accum       = r_accum;
        n_overflow    = r_overflow;
        n_octal       = r_octal;
        n_oct_inv     = r_oct_inv;
        w_idle_go     = 1'b0;
        w_cnt         = 2'd0;
        w_res         = '0;

        if (w_acc && i_has_char) begin
            unique case (r_mode)
                erle_pkg::M_IDLE: begin
                    w_idle_go = 1'b1;
                end
                erle_pkg::M_ESC: begin
                    n_mode = erle_pkg::M_IDLE;
                    if (i_char_in == erle_pkg::CH_LOW_N) begin
                        w_res[w_cnt] = erle_pkg::mk_res(erle_pkg::BYTE_LF, 17'd1, 1'b0,
                                                        erle_pkg::ST_OK);
                        w_cnt = w_cnt + 2'd1;
                    end else if (i_char_in == erle_pkg::CH_LOW_T) begin
                        w_res[w_cnt] = erle_pkg::mk_res(erle_pkg::BYTE_TAB, 17'd1, 1'b0,
                                                        erle_pkg::ST_OK);
                        w_cnt = w_cnt + 2'd1;
                    end else if (i_char_in == erle_pkg::CH_LOW_X) begin
                        n_mode = erle_pkg::M_HEX0;
                    end else begin
                        w_res[w_cnt] = erle_pkg::mk_res(i_char_in, 17'd1, 1'b0,
                                                        erle_pkg::ST_OK);
                        w_cnt = w_cnt + 2'd1;
                    end
                end
                erle_pkg::M_HEX0: begin
                    n_hex_invalid = !w_nib_ok;
                    n_high_nibble = w_nib;
                    n_mode        = erle_pkg::M_HEX1;
                end
                erle_pkg::M_HEX1: begin
                    if (!w_nib_ok || r_hex_invalid) begin
                        w_res[w_cnt] = erle_pkg::mk_res(8'h00, 17'd0, 1'b1,
                                                        erle_pkg::ST_BAD_HEX);
                        w_cnt  = w_cnt + 2'd1;
                        n_mode = erle_pkg::M_DRAIN;
                    end else begin
                        w_res[w_cnt] = erle_pkg::mk_res({r_high_nibble, w_nib}, 17'd1, 1'b0,
                                                        erle_pkg::ST_OK);
                        w_cnt  = w_cnt + 2'd1;
                        n_mode = erle_pkg::M_IDLE;
                    end
                end
                erle_pkg::M_TILDE: begin
                    if (w_digit) begin
                        n_octal = (i_char_in == erle_pkg::CH_ZERO);
                        n_accum = {60'd0, w_d};
                        n_mode  = erle_pkg::M_DIGITS;
                    end else begin
                        w_res[w_cnt] = erle_pkg::mk_res(erle_pkg::CH_TILDE, 17'd1, 1'b0,
                                                        erle_pkg::ST_OK);
                        w_cnt     = w_cnt + 2'd1;
                        w_idle_go = 1'b1;
                    end
                end
                erle_pkg::M_DIGITS: begin
                    if (w_digit) begin
                        if (r_octal) begin
                            if (w_d > 4'd7) n_oct_inv = 1'b1;
                            if (|r_accum[63:61]) n_overflow = 1'b1;
                            n_accum = {r_accum[60:0], w_d[2:0]};
                        end else begin
                            if (|w_dec[67:64]) n_overflow = 1'b1;
                            n_accum = w_dec[63:0];
                        end
                    end else if (i_char_in == erle_pkg::CH_COLON) begin
                        if (r_overflow || r_oct_inv) begin
                            w_res[w_cnt] = erle_pkg::mk_res(8'h00, 17'd0, 1'b1,
                                                            erle_pkg::ST_BAD_NUMBER);
                            w_cnt  = w_cnt + 2'd1;
                            n_mode = erle_pkg::M_DRAIN;
                        end else if (r_accum > 64'(MAX_REPEAT)) begin
                            w_res[w_cnt] = erle_pkg::mk_res(8'h00, 17'd0, 1'b1,
                                                            erle_pkg::ST_TOO_LARGE);
                            w_cnt  = w_cnt + 2'd1;
                            n_mode = erle_pkg::M_DRAIN;
                        end else begin
                            n_mode = erle_pkg::M_VALUE;
                        end
                    end else begin
                        w_res[w_cnt] = erle_pkg::mk_res(erle_pkg::CH_TILDE, 17'd1, 1'b0,
                                                        erle_pkg::ST_OK);
                        w_cnt     = w_cnt + 2'd1;
                        w_idle_go = 1'b1;
                    end
                end
                erle_pkg::M_VALUE: begin
                    w_res[w_cnt] = erle_pkg::mk_res(i_char_in, r_accum[16:0], 1'b0,
                                                    erle_pkg::ST_OK);
                    w_cnt  = w_cnt + 2'd1;
                    n_mode = erle_pkg::M_IDLE;
                end
                erle_pkg::M_DRAIN: begin
                end
                default: begin
                end
            endcase

            if (w_idle_go) begin
                priority if (i_char_in == erle_pkg::CH_BSLASH) begin
                    n_mode = erle_pkg::M_ESC;
                end else if (i_char_in == erle_pkg::CH_TILDE) begin
                    n_mode     = erle_pkg::M_TILDE;
                    n_accum    = 64'd0;
                    n_overflow = 1'b0;
                    n_octal    = 1'b0;
                    n_oct_inv  = 1'b0;
                end else begin
                    w_res[w_cnt] = erle_pkg::mk_res(i_char_in, 17'd1, 1'b0, erle_pkg::ST_OK);
                    w_cnt  = w_cnt + 2'd1;
                    n_mode = erle_pkg::M_IDLE;
                end
            end
        end

        if (w_acc && i_payload_end) begin
            unique case (n_mode)
                erle_pkg::M_IDLE: begin
                    w_res[w_cnt] = erle_pkg::mk_res(8'h00, 17'd0, 1'b1, erle_pkg::ST_OK);
                    w_cnt = w_cnt + 2'd1;
                end
                erle_pkg::M_ESC: begin
                    w_res[w_cnt] = erle_pkg::mk_res(erle_pkg::CH_BSLASH, 17'd1, 1'b0,
                                                    erle_pkg::ST_OK);
                    w_cnt = w_cnt + 2'd1;
                    w_res[w_cnt] = erle_pkg::mk_res(8'h00, 17'd0, 1'b1, erle_pkg::ST_OK);
                    w_cnt = w_cnt + 2'd1;
                end
                erle_pkg::M_HEX0, erle_pkg::M_HEX1: begin
                    w_res[w_cnt] = erle_pkg::mk_res(8'h00, 17'd0, 1'b1,
                                                    erle_pkg::ST_SHORT_HEX);
                    w_cnt = w_cnt + 2'd1;
                end
                erle_pkg::M_TILDE, erle_pkg::M_DIGITS: begin
                    w_res[w_cnt] = erle_pkg::mk_res(erle_pkg::CH_TILDE, 17'd1, 1'b0,
                                                    erle_pkg::ST_OK);
                    w_cnt = w_cnt + 2'd1;
                    w_res[w_cnt] = erle_pkg::mk_res(8'h00, 17'd0, 1'b1, erle_pkg::ST_OK);
                    w_cnt = w_cnt + 2'd1;
                end
                erle_pkg::M_VALUE: begin
                    w_res[w_cnt] = erle_pkg::mk_res(8'h00, 17'd0, 1'b1,
                                                    erle_pkg::ST_MISSING_VALUE);
                    w_cnt = w_cnt + 2'd1;
                end
                erle_pkg::M_DRAIN: begin
                end
                default: begin
                end
            endcase
            n_mode        = erle_pkg::M_IDLE;
            n_high_nibble = 4'd0;
            n_hex_invalid = 1'b0;
            n_accum       = 64'd0;
            n_overflow    = 1'b0;
            n_octal       = 1'b0;
            n_oct_inv     = 1'b0;
        end
    end

    assign o_push        = w_acc && (w_cnt != 2'd0);
    assign o_bundle.cnt  = w_cnt;
    assign o_bundle.res  = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= erle_pkg::M_IDLE;
            r_high_nibble <= 4'd0;
            r_hex_invalid <= 1'b0;
            r_accum       <= 64'd0;
            r_overflow    <= 1'b0;
            r_octal       <= 1'b0;
            r_oct_inv     <= 1'b0;
        end else begin
            r_mode        <= n_mode;
            r_high_nibble <= n_high_nibble;
            r_hex_invalid <= n_hex_invalid;
            r_accum       <= n_accum;
            r_overflow    <= n_overflow;
            r_octal       <= n_octal;
            r_oct_inv     <= n_oct_inv;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_payload_end) |=> (r_mode == erle_pkg::M_IDLE && r_accum == 64'd0))
        else $error("mode not cleared after payload end");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("push into full queue");

endmodule

>>> hw/rtl/erle_queue.sv
`timescale 1ns / 1ps

module erle_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  erle_pkg::t_bundle i_wdata,
    output logic              o_full,
    output logic              o_nempty,
    output erle_pkg::t_bundle o_rdata,
    input  logic              i_pop
);

    localparam int unsigned PW = (erle_pkg::QUEUE_DEPTH > 1) ?
                                 $clog2(erle_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(erle_pkg::QUEUE_DEPTH + 1);

    erle_pkg::t_bundle r_mem [erle_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     r_wr, r_rd;
    logic [CW-1:0]     r_count;

    assign o_full   = (r_count == CW'(erle_pkg::QUEUE_DEPTH));
    assign o_nempty = (r_count != '0);
    assign o_rdata  = r_mem[r_rd];

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        return (p == PW'(erle_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= ptr_inc(r_wr);
            if (i_pop)  r_rd <= ptr_inc(r_rd);
            if (i_push && !i_pop)      r_count <= r_count + CW'(1);
            else if (!i_push && i_pop) r_count <= r_count - CW'(1);
        end
    end

    a_pop_nempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nempty)
        else $error("pop from empty queue");

endmodule

>>> hw/rtl/erle_back.sv
`timescale 1ns / 1ps

module erle_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_nempty,
    input  erle_pkg::t_bundle i_q_data,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_run_byte,
    output logic [16:0]       o_run_length,
    output logic              o_is_status,
    output logic [2:0]        o_status_code,
    output logic              o_item_last
);

    logic              r_valid;
    logic [1:0]        r_idx;
    erle_pkg::t_result r_out;
    logic              r_last;
    logic              w_load;
    logic              w_is_last;

    assign w_load    = i_q_nempty && (!r_valid || !i_stall);
    assign w_is_last = (r_idx == i_q_data.cnt - 2'd1);
    assign o_q_pop   = w_load && w_is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= w_is_last ? 2'd0 : r_idx + 2'd1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out  <= i_q_data.res[r_idx];
            r_last <= w_is_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_run_byte    = r_out.run_byte;
    assign o_run_length  = r_out.run_length;
    assign o_is_status   = r_out.is_status;
    assign o_status_code = r_out.status_code;
    assign o_item_last   = r_last;

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.is_status) |-> r_last)
        else $error("status word not last of its item");

    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.is_status) |-> (r_out.run_length == 17'd0
                                         && r_out.run_byte == 8'h00))
        else $error("status word carries run data");

endmodule

>>> hw/rtl/escaped_run_length_expander_top.sv
// A result word is written into the queue, then registered in the result stage.
// Throughput: one input word per cycle while i_stall is low and each word yields
//   at most one result; the k results (k up to 3) of a word leave one at a time.
// A two-entry queue of per-word result groups sits between parser and result stage.
// Reset: synchronous active-low i_rst_n clears parser state, queue and output valid.
`timescale 1ns / 1ps

module escaped_run_length_expander_top #(
    parameter int unsigned MAX_REPEAT = erle_pkg::MAX_REPEAT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_has_char,
    input  logic        i_payload_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_run_byte,
    output logic [16:0] o_run_length,
    output logic        o_is_status,
    output logic [2:0]  o_status_code,
    output logic        o_item_last
);

    logic              w_push;
    logic              w_full;
    logic              w_nempty;
    logic              w_pop;
    erle_pkg::t_bundle w_wdata;
    erle_pkg::t_bundle w_rdata;

    erle_front #(
        .MAX_REPEAT(MAX_REPEAT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_in     (i_char_in),
        .i_has_char    (i_has_char),
        .i_payload_end (i_payload_end),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_bundle      (w_wdata)
    );

    erle_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_wdata  (w_wdata),
        .o_full   (w_full),
        .o_nempty (w_nempty),
        .o_rdata  (w_rdata),
        .i_pop    (w_pop)
    );

    erle_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_nempty    (w_nempty),
        .i_q_data      (w_rdata),
        .o_q_pop       (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_run_byte    (o_run_byte),
        .o_run_length  (o_run_length),
        .o_is_status   (o_is_status),
        .o_status_code (o_status_code),
        .o_item_last   (o_item_last)
    );

endmodule
